/* src/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on each rising clock edge, off while reset is asserted.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/gww_pkg.sv */
// Shared types and constants of the greedy word wrap block.
`default_nettype none

package gww_pkg;

    localparam int MAX_LINE_DEF = 4096;

    localparam int CH_W     = 8;
    localparam int BRK_W    = 13;
    localparam int CNT_W    = 9;
    localparam int COLS_W   = 10;
    localparam int CELL_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

    localparam logic [2:0] TAB_CELLS  = 3'd4;
    localparam logic [2:0] CHAR_CELLS = 3'd1;

    localparam logic [COLS_W-1:0] WRAP_COLS_RST = 10'd80;
    localparam logic [CNT_W-1:0]  ROWS_LIMIT    = 9'd256;

    localparam int QUEUE_DEPTH = 2;

    localparam logic KIND_BREAK = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRAP_COLS = 2'd0,
        CFG_MAX_ROWS  = 2'd1
    } t_cfg_idx;

    // Classified input item as it travels through the queue.
    typedef struct packed {
        logic is_tab;
        logic is_space;
        logic has_byte;
        logic last;
    } t_item;

    // Effective (clamped) configuration.
    typedef struct packed {
        logic [COLS_W-1:0] cols;
        logic [CNT_W-1:0]  lim;
    } t_cfg;

    typedef struct packed {
        logic             kind;
        logic [BRK_W-1:0] break_pos;
        logic [CNT_W-1:0] row_count;
        logic             end_of_run;
    } t_result;

endpackage

`default_nettype wire

/* src/gww_if.sv */
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface gww_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output ch_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input ch_byte, input has_byte, input last,
                    output ready);
endinterface

interface gww_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [12:0] break_pos;
    logic [8:0]  row_count;
    logic        end_of_run;

    modport source (output valid, output kind, output break_pos, output row_count,
                    output end_of_run, input ready);
    modport sink   (input valid, input kind, input break_pos, input row_count,
                    input end_of_run, output ready);
endinterface

`default_nettype wire

/* src/gww_front.sv */
// Front end: accepts input transactions, classifies the byte, drops idle items.
`default_nettype none

module gww_front (
    gww_in_if.sink          i_in,
    output logic            o_push_valid,
    output gww_pkg::t_item  o_push_item,
    input  logic            i_push_ready
);
    import gww_pkg::*;

    // Idle items (no byte, no end) carry nothing; accept and discard them.
    assign o_push_valid = i_in.valid && (i_in.has_byte || i_in.last);
    assign i_in.ready   = i_push_ready;

    always_comb begin
        o_push_item.is_tab   = i_in.has_byte && (i_in.ch_byte == CH_TAB);
        o_push_item.is_space = i_in.has_byte && (i_in.ch_byte == CH_SPACE);
        o_push_item.has_byte = i_in.has_byte;
        o_push_item.last     = i_in.last;
    end

endmodule

`default_nettype wire

/* src/gww_queue.sv */
// Short FIFO of classified items between front end and wrap engine.
`default_nettype none
`include "assert_macros.svh"

module gww_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  gww_pkg::t_item i_push_item,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output gww_pkg::t_item o_pop_item,
    input  logic           i_pop
);
    import gww_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    t_item             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_QW-1:0] r_count, n_count;
    logic              push, pop;

    assign o_push_ready = (r_count != CNT_QW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
        end
        if (push && !pop) begin
            n_count = CNT_QW'(r_count + 1'b1);
        end else if (pop && !push) begin
            n_count = CNT_QW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_QW'(QUEUE_DEPTH), "queue count past depth")
    `ASSERT_IMPLY(a_full_blocks, i_clk, i_rst_n, r_count == CNT_QW'(QUEUE_DEPTH), !o_push_ready, "full")
    `ASSERT_IMPLY(a_empty_idle, i_clk, i_rst_n, r_count == '0, !o_pop_valid, "empty queue offers item")

endmodule

`default_nettype wire

/* src/gww_back.sv */
// Wrap engine: line state, break decisions and the result output register.
`default_nettype none
`include "assert_macros.svh"

module gww_back #(
    parameter int MAX_LINE = gww_pkg::MAX_LINE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gww_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  gww_pkg::t_item i_q_item,
    output logic           o_q_pop,
    gww_out_if.source      o_out
);
    import gww_pkg::*;

    localparam int IDX_W = $clog2(MAX_LINE + 1);
    localparam int PW    = (IDX_W > BRK_W) ? IDX_W : BRK_W;
    localparam int SUM_W = CELL_W + 1;
    localparam logic [PW-1:0] LINE_END = PW'(MAX_LINE);

    // line state
    logic [PW-1:0]     r_bi, n_bi;
    logic [PW-1:0]     r_rsp, n_rsp;
    logic [PW-1:0]     r_sp, n_sp;
    logic              r_ss, n_ss;
    logic [CELL_W-1:0] r_rc, n_rc;
    logic [CELL_W-1:0] r_cas, n_cas;
    logic [CNT_W-1:0]  r_rows, n_rows;
    logic              r_sat, n_sat;

    logic [1:0] r_sub;
    logic       r_out_valid;
    t_result    r_out, res;

    logic [2:0]        w;
    logic              active;
    logic              need1, sat1, e1, need2, sat2, e2, sat_new, upd;
    logic [PW-1:0]     brk1, rsp1, rsp2, i_nxt;
    logic [CELL_W-1:0] rc1, rc2;
    logic [CNT_W-1:0]  rows1, rows2;
    logic              ss1;
    logic [1:0]        n_res, last_sub;
    logic              can_load, emit, pop;

    assign w      = i_q_item.is_tab ? TAB_CELLS : CHAR_CELLS;
    assign active = i_q_item.has_byte && !r_sat && (r_bi < LINE_END);
    assign i_nxt  = PW'(r_bi + 1'b1);

    // first break check
    always_comb begin
        need1 = active && ((SUM_W'(r_rc) + SUM_W'(w)) > SUM_W'(i_cfg.cols))
                && (r_bi > r_rsp);
        brk1  = r_ss ? r_sp : r_bi;
        sat1  = need1 && (r_rows >= i_cfg.lim);
        e1    = need1 && !sat1;
        rows1 = e1 ? CNT_W'(r_rows + 1'b1) : r_rows;
        rc1   = e1 ? ((brk1 != r_bi) ? r_cas : '0) : r_rc;
        rsp1  = e1 ? brk1 : r_rsp;
        ss1   = e1 ? 1'b0 : r_ss;
    end

    // second check: only after a break at the last space
    always_comb begin
        need2 = e1 && ((SUM_W'(rc1) + SUM_W'(w)) > SUM_W'(i_cfg.cols))
                && (r_bi > rsp1);
        sat2  = need2 && (rows1 >= i_cfg.lim);
        e2    = need2 && !sat2;
        rows2 = e2 ? CNT_W'(rows1 + 1'b1) : rows1;
        rc2   = e2 ? '0 : rc1;
        rsp2  = e2 ? r_bi : rsp1;
    end

    assign sat_new = sat1 || sat2;
    assign upd     = active && !sat_new;

    assign n_res    = 2'({1'b0, e1}) + 2'({1'b0, e2}) + 2'({1'b0, i_q_item.last});
    assign last_sub = 2'(n_res - 2'd1);

    // result number r_sub of the current item: breaks first, then the total
    always_comb begin
        res.kind       = KIND_TOTAL;
        res.break_pos  = '0;
        res.row_count  = rows2;
        res.end_of_run = (r_sub == last_sub);
        if ((r_sub == 2'd0) && e1) begin
            res.kind      = KIND_BREAK;
            res.break_pos = brk1[BRK_W-1:0];
            res.row_count = '0;
        end else if ((r_sub == 2'd1) && e2) begin
            res.kind      = KIND_BREAK;
            res.break_pos = r_bi[BRK_W-1:0];
            res.row_count = '0;
        end
    end

    assign can_load = !r_out_valid || o_out.ready;
    assign emit     = i_q_valid && can_load && (n_res != 2'd0);
    assign pop      = i_q_valid && ((n_res == 2'd0) || (emit && (r_sub == last_sub)));
    assign o_q_pop  = pop;

    always_comb begin
        n_bi   = r_bi;
        n_rsp  = r_rsp;
        n_sp   = r_sp;
        n_ss   = r_ss;
        n_rc   = r_rc;
        n_cas  = r_cas;
        n_rows = r_rows;
        n_sat  = r_sat;
        if (pop) begin
            if (i_q_item.last) begin
                n_bi   = '0;
                n_rsp  = '0;
                n_sp   = '0;
                n_ss   = 1'b0;
                n_rc   = '0;
                n_cas  = '0;
                n_rows = CNT_W'(1);
                n_sat  = 1'b0;
            end else begin
                n_rows = rows2;
                n_rc   = rc2;
                n_rsp  = rsp2;
                n_ss   = ss1;
                n_sat  = r_sat || sat_new;
                if (upd) begin
                    n_rc = CELL_W'(rc2 + CELL_W'(w));
                    n_bi = i_nxt;
                    if (i_q_item.is_space) begin
                        n_ss  = 1'b1;
                        n_sp  = i_nxt;
                        n_cas = '0;
                    end else begin
                        n_cas = CELL_W'(r_cas + CELL_W'(w));
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bi        <= '0;
            r_rsp       <= '0;
            r_sp        <= '0;
            r_ss        <= 1'b0;
            r_rc        <= '0;
            r_cas       <= '0;
            r_rows      <= CNT_W'(1);
            r_sat       <= 1'b0;
            r_sub       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_bi   <= n_bi;
            r_rsp  <= n_rsp;
            r_sp   <= n_sp;
            r_ss   <= n_ss;
            r_rc   <= n_rc;
            r_cas  <= n_cas;
            r_rows <= n_rows;
            r_sat  <= n_sat;
            if (emit) begin
                r_sub <= pop ? 2'd0 : 2'(r_sub + 2'd1);
            end
            if (can_load) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out.kind;
    assign o_out.break_pos  = r_out.break_pos;
    assign o_out.row_count  = r_out.row_count;
    assign o_out.end_of_run = r_out.end_of_run;

    `ASSERT_IMPLY(a_total_ends_run, i_clk, i_rst_n, r_out_valid && (r_out.kind == KIND_TOTAL), r_out.end_of_run, "total not marked end of run")
    `ASSERT_IMPLY(a_sub_in_range, i_clk, i_rst_n, i_q_valid && (n_res != 2'd0), r_sub < n_res, "result index past item results")
    `ASSERT_ALWAYS(a_rows_range, i_clk, i_rst_n, (r_rows != '0) && (r_rows <= ROWS_LIMIT), "row count out of range")

endmodule

`default_nettype wire

/* src/greedy_word_wrap_top.sv */
// Top level of the greedy word wrap block: config registers, front end, queue, engine.
//
//  channel  | dir | handshake                | payload
//  ---------+-----+--------------------------+------------------------------------------
//  i_in     | in  | valid / ready            | ch_byte, has_byte, last
//  o_out    | out | valid / ready            | kind, break_pos, row_count, end_of_run
//  cfg      | in  | i_cfg_valid/o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Flow: one input transaction per cycle while the queue has room. An item that yields
//   k results (k <= 3) stays at the queue head until its last result is loaded into the
//   output register; items yielding none retire even while the output is stalled. Break
//   checks and state update are done in the wrap engine on the queue head.
// Reset: synchronous, active low; clears line state, queue and output, and loads
//   an 80-cell row width and a 256-row limit. No clearing pass.
// Stalls: a two-entry queue decouples the front end from the engine; the output
//   register decouples the engine from the consumer. Config writes are always taken.
`default_nettype none

module greedy_word_wrap_top #(
    parameter int MAX_LINE = gww_pkg::MAX_LINE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gww_in_if.sink                            i_in,
    gww_out_if.source                         o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gww_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gww_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import gww_pkg::*;

    t_cfg  r_cfg;
    logic  push_valid, push_ready;
    t_item push_item;
    logic  q_valid, q_pop;
    t_item q_item;

    logic [COLS_W-1:0] wr_cols;
    logic [CNT_W-1:0]  wr_rows;

    // Registers are stored already clamped: width 0 acts as 1, row limit in 1..256.
    assign o_cfg_ready = 1'b1;
    assign wr_cols = (i_cfg_data[COLS_W-1:0] == '0) ? COLS_W'(1) : i_cfg_data[COLS_W-1:0];
    always_comb begin
        if (i_cfg_data[CNT_W-1:0] == '0) begin
            wr_rows = CNT_W'(1);
        end else if (i_cfg_data[CNT_W-1:0] > ROWS_LIMIT) begin
            wr_rows = ROWS_LIMIT;
        end else begin
            wr_rows = i_cfg_data[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cols <= WRAP_COLS_RST;
            r_cfg.lim  <= ROWS_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WRAP_COLS: r_cfg.cols <= wr_cols;
                CFG_MAX_ROWS:  r_cfg.lim  <= wr_rows;
                default: ;  // unused register index: write ignored
            endcase
        end
    end

    gww_front u_front (
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    gww_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (q_valid),
        .o_pop_item   (q_item),
        .i_pop        (q_pop)
    );

    gww_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

/* sim/greedy_word_wrap_checker.sv */
// Scoreboard for the greedy word wrap block: tracks rows per line and checks each result.
`timescale 1ns / 1ps

module greedy_word_wrap_checker
    import gww_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gww_in_if                     in_ch,
    gww_out_if                    out_ch,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_breaks,
    output int                    o_lines,
    output int                    o_double_breaks,
    output int                    o_saturated_lines
);

    // Register copies
    logic [COLS_W-1:0] cell_width;
    logic [CNT_W-1:0]  max_rows;

    // Line state
    logic [BRK_W-1:0]  byte_index;
    logic [BRK_W-1:0]  row_base;
    logic [BRK_W-1:0]  space_pos;
    logic              space_seen;
    logic [CELL_W-1:0] row_cells;
    logic [CELL_W-1:0] cells_after_space;
    logic [CNT_W-1:0]  rows_so_far;
    logic              saturated;

    t_result rows_due[$];
    t_result due;

    int fails     = 0;
    int breaks    = 0;
    int lines     = 0;
    int doubles   = 0;
    int sat_lines = 0;

    function automatic void clear_line();
        byte_index        = '0;
        row_base          = '0;
        space_pos         = '0;
        space_seen        = 1'b0;
        row_cells         = '0;
        cells_after_space = '0;
        rows_so_far       = 9'd1;
        saturated         = 1'b0;
    endfunction

    // Folds one accepted byte into the current row and queues the row starts it forces.
    function automatic void advance_wrap(input logic [CH_W-1:0] ch, input logic has,
                                         input logic lst);
        logic [COLS_W-1:0] cols;
        logic [CNT_W-1:0]  lim;
        logic [2:0]        w;
        logic [BRK_W-1:0]  brk;
        logic              stop;
        t_result           batch [0:2];
        int                made;
        cols = (cell_width == '0) ? 10'd1 : cell_width;
        lim  = (max_rows == '0) ? 9'd1 : ((max_rows > ROWS_LIMIT) ? ROWS_LIMIT : max_rows);
        made = 0;
        stop = 1'b0;
        if (has && !saturated && byte_index < MAX_LINE) begin
            w = (ch == CH_TAB) ? TAB_CELLS : CHAR_CELLS;
            // A byte that still overflows after one break is retried once
            for (int pass = 0; pass < 2; pass++) begin
                if (!stop && row_cells + w > cols && byte_index > row_base) begin
                    brk = space_seen ? space_pos : byte_index;
                    if (rows_so_far >= lim) begin
                        saturated = 1'b1;
                        stop      = 1'b1;
                    end else begin
                        batch[made] = '{kind: KIND_BREAK, break_pos: brk, row_count: '0,
                                        end_of_run: 1'b0};
                        made++;
                        rows_so_far++;
                        row_cells   = (brk != byte_index) ? cells_after_space : '0;
                        row_base    = brk;
                        space_seen  = 1'b0;
                    end
                end else begin
                    stop = 1'b1;
                end
            end
            if (made == 2) doubles++;
            breaks += made;
            if (!saturated) begin
                row_cells += w;
                if (ch == CH_SPACE) begin
                    space_seen        = 1'b1;
                    space_pos         = byte_index + 1'b1;
                    cells_after_space = '0;
                end else begin
                    cells_after_space += w;
                end
                byte_index++;
            end
        end
        if (lst) begin
            batch[made] = '{kind: KIND_TOTAL, break_pos: '0, row_count: rows_so_far,
                            end_of_run: 1'b0};
            made++;
            lines++;
            if (saturated) sat_lines++;
            clear_line();
        end
        if (made > 0) batch[made-1].end_of_run = 1'b1;
        for (int k = 0; k < made; k++) rows_due.push_back(batch[k]);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cell_width = WRAP_COLS_RST;
            max_rows   = ROWS_LIMIT;
            clear_line();
            rows_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_WRAP_COLS) cell_width = i_cfg_data[COLS_W-1:0];
                else if (i_cfg_index == CFG_MAX_ROWS) max_rows = i_cfg_data[CNT_W-1:0];
            end
            if (in_ch.valid && in_ch.ready)
                advance_wrap(in_ch.ch_byte, in_ch.has_byte, in_ch.last);
            if (out_ch.valid && out_ch.ready) begin
                if (rows_due.size() == 0) begin
                    report_mismatch($sformatf("result with nothing due: kind %0d pos %0d rows %0d",
                                              out_ch.kind, out_ch.break_pos, out_ch.row_count));
                end else begin
                    due = rows_due.pop_front();
                    if (out_ch.kind !== due.kind)
                        report_mismatch($sformatf("kind expected %0d got %0d",
                                                  due.kind, out_ch.kind));
                    if (out_ch.break_pos !== due.break_pos)
                        report_mismatch($sformatf("break_pos expected %0d got %0d",
                                                  due.break_pos, out_ch.break_pos));
                    if (out_ch.row_count !== due.row_count)
                        report_mismatch($sformatf("row_count expected %0d got %0d",
                                                  due.row_count, out_ch.row_count));
                    if (out_ch.end_of_run !== due.end_of_run)
                        report_mismatch($sformatf("end_of_run expected %0d got %0d",
                                                  due.end_of_run, out_ch.end_of_run));
                end
            end
        end
        o_fail_count      <= fails;
        o_pending         <= rows_due.size();
        o_breaks          <= breaks;
        o_lines           <= lines;
        o_double_breaks   <= doubles;
        o_saturated_lines <= sat_lines;
    end

endmodule

/* sim/greedy_word_wrap_top_tb.sv */
// Testbench top for the greedy word wrap block: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module greedy_word_wrap_top_tb;
    import gww_pkg::*;

    localparam int IDLE_PCT      = 7;      // chance of an idle cycle per side, in percent
    localparam int SETTLE_CYCLES = 8;      // queue + engine + output register, with margin
    localparam int STUCK_LIMIT   = 2000;   // cycles without any transaction before giving up
    localparam int PHASE_ITEMS   = 38;     // line items per random config phase
    localparam int NUM_PHASES    = 8;
    localparam int LINE_LIMIT    = 64;     // short byte limit so the long line stays small
    localparam int LONG_LINE     = LINE_LIMIT + 20;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    t_cfg_idx              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  sink_ready = 1'b0;

    // Idling switches; cleared for the stretches that run at full rate
    logic gaps_on   = 1'b1;
    logic stalls_on = 1'b1;

    int stuck_cycles = 0;
    int sent_items   = 0;   // items carrying a byte or an end of line
    int phase_start;

    int fail_count;
    int pending;
    int breaks;
    int lines;
    int doubles;
    int sat_lines;

    gww_in_if  in_ch();
    gww_out_if out_ch();

    assign out_ch.ready = sink_ready;

    greedy_word_wrap_top #(
        .MAX_LINE (LINE_LIMIT)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    greedy_word_wrap_checker #(
        .MAX_LINE (LINE_LIMIT)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .in_ch             (in_ch),
        .out_ch            (out_ch),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_breaks          (breaks),
        .o_lines           (lines),
        .o_double_breaks   (doubles),
        .o_saturated_lines (sat_lines)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Result side: drop ready now and then while stalls are on
    always @(posedge i_clk) begin
        sink_ready <= !stalls_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: any input, output or config transaction resets the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STUCK_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // One input transaction. Valid stays high across back-to-back items and
    // is only lowered for a random gap, so no step sees two writes to it.
    task automatic send_item(input logic [CH_W-1:0] ch, input logic has, input logic lst);
        if (gaps_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid    <= 1'b1;
        in_ch.ch_byte  <= ch;
        in_ch.has_byte <= has;
        in_ch.last     <= lst;
        do @(posedge i_clk); while (!in_ch.ready);
        if (has || lst) sent_items++;
    endtask

    // Stop sending and wait until every predicted result has been taken.
    // The checker's count is registered, hence the wait for an edge before looking.
    task automatic hold_for_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Idle point: results drained, plus time for resultless items still in the pipe
    task automatic quiesce();
        hold_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Both registers in one burst; valid stays high between the two writes
    task automatic load_config(input logic [CFG_DATA_W-1:0] wrap,
                               input logic [CFG_DATA_W-1:0] rows);
        quiesce();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WRAP_COLS;
        cfg_data  <= wrap;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_index <= CFG_MAX_ROWS;
        cfg_data  <= rows;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Text-like byte mix: mostly letters, plenty of spaces and tabs, some raw bytes
    function automatic logic [CH_W-1:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 55) return CH_W'($urandom_range(122, 97));
        if (r < 75) return CH_SPACE;
        if (r < 87) return CH_TAB;
        return CH_W'($urandom_range(255));
    endfunction

    // One line of len bytes. The end marker rides on the last byte or comes as
    // its own byteless item; idle items with junk bytes are mixed in as noise.
    task automatic send_line(input int len);
        logic end_only;
        int   pause_at;
        end_only = (len == 0) || ($urandom_range(4) == 0);
        pause_at = ($urandom_range(19) == 0) ? $urandom_range(len) : -1;
        for (int k = 0; k < len; k++) begin
            if (k == pause_at) hold_for_results();
            if ($urandom_range(24) == 0) send_item(CH_W'($urandom), 1'b0, 1'b0);
            send_item(pick_char(), 1'b1, !end_only && (k == len - 1));
        end
        if (end_only) send_item(CH_W'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        in_ch.valid    <= 1'b0;
        in_ch.ch_byte  <= '0;
        in_ch.has_byte <= 1'b0;
        in_ch.last     <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_WRAP_COLS;
        cfg_data       <= '0;
        i_rst_n        <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- Directed: reset settings (80 cells, 256 rows) ----
        // Byte extremes, a tab and a space: no break at this width
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(CH_TAB, 1'b1, 1'b0);
        send_item(CH_SPACE, 1'b1, 1'b0);
        // Idle item: no byte, no end, must leave no trace
        send_item(8'hA5, 1'b0, 1'b0);
        // Byteless end closes the line: one row
        send_item(8'h5A, 1'b0, 1'b1);
        // Empty line: byteless end with nothing before it
        send_item(8'hFF, 1'b0, 1'b1);

        // Width 4, "a b<tab>": the tab breaks after the space, then again
        // at itself, and ends the line -- three results from one item
        load_config(10'd4, 10'd256);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(CH_SPACE, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(CH_TAB, 1'b1, 1'b1);

        // Width 0 acts as 1; two rows allowed, so the third byte saturates
        // the line and the rest is dropped
        load_config(10'd0, 10'd2);
        send_item(8'h78, 1'b1, 1'b0);
        send_item(8'h79, 1'b1, 1'b0);
        send_item(8'h7A, 1'b1, 1'b0);
        send_item(8'h77, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);

        // Row limit 0 acts as 1: the first break saturates
        load_config(10'd0, 10'd0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);

        // ---- Long line past the byte limit, at full rate on both sides ----
        load_config(10'd1023, 10'd256);
        gaps_on   <= 1'b0;
        stalls_on <= 1'b0;
        for (int k = 0; k < LONG_LINE; k++)
            send_item(pick_char(), 1'b1, k == LONG_LINE - 1);

        // ---- Random lines over a sweep of settings ----
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: load_config(10'd1, 10'd511);      // one cell per row, limit above range
                1: load_config(10'd4, 10'd256);      // tab-wide rows: double breaks
                2: load_config(10'd0, 10'd3);        // zero width, early saturation
                3: load_config(10'd1023, 10'd1);     // widest rows, single row allowed
                4: load_config(10'd7, 10'd0);        // zero row limit
                5: load_config(CFG_DATA_W'($urandom_range(20, 1)),
                               CFG_DATA_W'($urandom_range(8, 2)));
                6: load_config(10'd12, 10'd256);     // run without idling
                default: load_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            endcase
            gaps_on     <= (p != 6);
            stalls_on   <= (p != 6);
            phase_start  = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS)
                send_line($urandom_range(30));
        end

        quiesce();

        $display("Covered %0d line items over %0d lines, %0d of them cut short by the row limit,",
                 sent_items, lines, sat_lines);
        $display("plus one line past %0d bytes; %0d row breaks checked, %0d bytes breaking twice.",
                 LINE_LIMIT, breaks, doubles);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
